// ----- hdl/pld_pkg.sv -----
// ----------------------------------------------------------------------------
// pld_pkg
// Shared widths, types and register codes for the point-to-line distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

  localparam int unsigned CW     = 32;   // coordinate width
  localparam int unsigned DW     = 33;   // coordinate difference width
  localparam int unsigned PW     = 66;   // product / squared difference width
  localparam int unsigned HW     = 33;   // half of a cross magnitude
  localparam int unsigned CSQ_W  = 132;  // |c|^2 width
  localparam int unsigned DSQ_W  = 66;   // |d|^2 width
  localparam int unsigned QW     = 64;   // quotient width
  localparam int unsigned RW     = 32;   // root / distance width
  localparam int unsigned EPS_W  = 16;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [ADDR_W-3:0] REG_EPS_THRESHOLD = 1'b0;
  localparam logic [EPS_W-1:0]  EPS_RESET         = 16'd1;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] line_a_x;
    logic signed [CW-1:0] line_a_y;
    logic signed [CW-1:0] line_a_z;
    logic signed [CW-1:0] line_b_x;
    logic signed [CW-1:0] line_b_y;
    logic signed [CW-1:0] line_b_z;
  } pld_query_t;

  typedef struct packed {
    logic vld;
    logic degen;
    logic sat;
  } pld_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/pld_if.sv -----
// ----------------------------------------------------------------------------
// pld_in_if / pld_out_if
// Valid/ready channels for query words and distance words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pld_in_if import pld_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  logic signed [CW-1:0] line_a_x;
  logic signed [CW-1:0] line_a_y;
  logic signed [CW-1:0] line_a_z;
  logic signed [CW-1:0] line_b_x;
  logic signed [CW-1:0] line_b_y;
  logic signed [CW-1:0] line_b_z;

  modport source (output valid, point_x, point_y, point_z, line_a_x, line_a_y,
                  line_a_z, line_b_x, line_b_y, line_b_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, line_a_x, line_a_y,
                  line_a_z, line_b_x, line_b_y, line_b_z, output ready);
endinterface

interface pld_out_if import pld_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [RW-1:0] distance;
  logic          degenerate;
  logic          saturated;

  modport source (output valid, distance, degenerate, saturated, input ready);
  modport sink   (input valid, distance, degenerate, saturated, output ready);
endinterface

`default_nettype wire

// ----- hdl/pld_front.sv -----
// ----------------------------------------------------------------------------
// pld_front
// Seven stages: differences, products, cross terms and |d|^2, split squares,
// per-axis |c|^2 terms, |c|^2 sum, saturation compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_front import pld_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               vld_i,
  input  wire pld_query_t         qry_i,
  input  wire logic [2*EPS_W-1:0] eps2_i,
  output pld_ctl_t                ctl_o,
  output logic [CSQ_W-1:0]        csq_o,
  output logic [DSQ_W-1:0]        dsq_o
);

  pld_ctl_t ctl_r [1:7];

  logic signed [DW-1:0] d_r [3];
  logic signed [DW-1:0] u_r [3];
  logic signed [PW-1:0] m_r [6];
  logic        [PW-1:0] dq_r [3];
  logic        [PW-1:0] cabs_r [3];
  logic        [DSQ_W-1:0] dsq3_r, dsq4_r, dsq5_r, dsq6_r, dsq7_r;
  logic        [PW-1:0] hh_r [3];
  logic        [PW-1:0] hl_r [3];
  logic        [PW-1:0] ll_r [3];
  logic        [CSQ_W-1:0] sq_r [3];
  logic        [CSQ_W-1:0] csq6_r, csq7_r;

  logic signed [PW:0]   c_nxt [3];
  logic        [PW:0]   cmag_nxt [3];
  logic        [DSQ_W-1:0] dsq_nxt;
  logic                 degen_nxt;

  // cross product (p-a) x d
  always_comb begin
    c_nxt[0] = {m_r[0][PW-1], m_r[0]} - {m_r[1][PW-1], m_r[1]};
    c_nxt[1] = {m_r[2][PW-1], m_r[2]} - {m_r[3][PW-1], m_r[3]};
    c_nxt[2] = {m_r[4][PW-1], m_r[4]} - {m_r[5][PW-1], m_r[5]};
    for (int i = 0; i < 3; i++) begin
      cmag_nxt[i] = c_nxt[i][PW] ? (-c_nxt[i]) : c_nxt[i];
    end
    dsq_nxt   = dq_r[0] + dq_r[1] + dq_r[2];
    degen_nxt = (dsq_nxt == '0) || (dsq_nxt < DSQ_W'(eps2_i));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 7; i++) ctl_r[i] <= '0;
    end else if (adv) begin
      ctl_r[1] <= '{vld: vld_i, degen: 1'b0, sat: 1'b0};
      ctl_r[2] <= ctl_r[1];
      ctl_r[3] <= '{vld: ctl_r[2].vld, degen: degen_nxt, sat: 1'b0};
      ctl_r[4] <= ctl_r[3];
      ctl_r[5] <= ctl_r[4];
      ctl_r[6] <= ctl_r[5];
      ctl_r[7] <= '{vld: ctl_r[6].vld, degen: ctl_r[6].degen,
                    sat: (csq6_r >= CSQ_W'({dsq6_r, {QW{1'b0}}}))};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      d_r[0] <= {qry_i.line_b_x[CW-1], qry_i.line_b_x} - {qry_i.line_a_x[CW-1], qry_i.line_a_x};
      d_r[1] <= {qry_i.line_b_y[CW-1], qry_i.line_b_y} - {qry_i.line_a_y[CW-1], qry_i.line_a_y};
      d_r[2] <= {qry_i.line_b_z[CW-1], qry_i.line_b_z} - {qry_i.line_a_z[CW-1], qry_i.line_a_z};
      u_r[0] <= {qry_i.point_x[CW-1], qry_i.point_x} - {qry_i.line_a_x[CW-1], qry_i.line_a_x};
      u_r[1] <= {qry_i.point_y[CW-1], qry_i.point_y} - {qry_i.line_a_y[CW-1], qry_i.line_a_y};
      u_r[2] <= {qry_i.point_z[CW-1], qry_i.point_z} - {qry_i.line_a_z[CW-1], qry_i.line_a_z};
      // stage 2
      m_r[0] <= PW'(u_r[1]) * PW'(d_r[2]);
      m_r[1] <= PW'(u_r[2]) * PW'(d_r[1]);
      m_r[2] <= PW'(u_r[2]) * PW'(d_r[0]);
      m_r[3] <= PW'(u_r[0]) * PW'(d_r[2]);
      m_r[4] <= PW'(u_r[0]) * PW'(d_r[1]);
      m_r[5] <= PW'(u_r[1]) * PW'(d_r[0]);
      for (int i = 0; i < 3; i++) begin
        dq_r[i] <= PW'(PW'(d_r[i]) * PW'(d_r[i]));
      end
      // stage 3
      for (int i = 0; i < 3; i++) begin
        cabs_r[i] <= cmag_nxt[i][PW-1:0];
      end
      dsq3_r <= dsq_nxt;
      // stage 4: |c| = h*2^33 + l
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= PW'(cabs_r[i][PW-1:HW]) * PW'(cabs_r[i][PW-1:HW]);
        hl_r[i] <= PW'(cabs_r[i][PW-1:HW]) * PW'(cabs_r[i][HW-1:0]);
        ll_r[i] <= PW'(cabs_r[i][HW-1:0]) * PW'(cabs_r[i][HW-1:0]);
      end
      dsq4_r <= dsq3_r;
      // stage 5
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (CSQ_W'(hh_r[i]) << (2*HW)) + (CSQ_W'(hl_r[i]) << (HW+1))
                   + CSQ_W'(ll_r[i]);
      end
      dsq5_r <= dsq4_r;
      // stage 6
      csq6_r <= sq_r[0] + sq_r[1] + sq_r[2];
      dsq6_r <= dsq5_r;
      // stage 7
      csq7_r <= csq6_r;
      dsq7_r <= dsq6_r;
    end
  end

  assign ctl_o = ctl_r[7];
  assign csq_o = csq7_r;
  assign dsq_o = dsq7_r;

endmodule

`default_nettype wire

// ----- hdl/pld_div.sv -----
// ----------------------------------------------------------------------------
// pld_div
// Restoring divider, one quotient bit per stage: q = floor(|c|^2 / |d|^2).
// ----------------------------------------------------------------------------
`default_nettype none

module pld_div import pld_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire pld_ctl_t          ctl_i,
  input  wire logic [CSQ_W-1:0]  csq_i,
  input  wire logic [DSQ_W-1:0]  dsq_i,
  output pld_ctl_t               ctl_o,
  output logic [QW-1:0]          quo_o
);

  pld_ctl_t          ctl_r [1:QW];
  logic [CSQ_W-1:0]  rem_r [1:QW];
  logic [DSQ_W-1:0]  div_r [1:QW];
  logic [QW-1:0]     quo_r [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    pld_ctl_t         ctl_cur;
    logic [CSQ_W-1:0] rem_cur;
    logic [DSQ_W-1:0] div_cur;
    logic [QW-1:0]    quo_cur;
    logic [CSQ_W-1:0] dsh;
    logic             take;
    logic [QW-1:0]    quo_nxt;

    if (k == 0) begin : g_first
      assign ctl_cur = ctl_i;
      assign rem_cur = csq_i;
      assign div_cur = dsq_i;
      assign quo_cur = '0;
    end else begin : g_rest
      assign ctl_cur = ctl_r[k];
      assign rem_cur = rem_r[k];
      assign div_cur = div_r[k];
      assign quo_cur = quo_r[k];
    end

    assign dsh  = CSQ_W'(div_cur) << (QW-1-k);
    assign take = (rem_cur >= dsh);
    always_comb begin
      quo_nxt = quo_cur;
      quo_nxt[QW-1-k] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (adv) begin
        ctl_r[k+1] <= ctl_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= take ? (rem_cur - dsh) : rem_cur;
        div_r[k+1] <= div_cur;
        quo_r[k+1] <= quo_nxt;
      end
    end
  end

  assign ctl_o = ctl_r[QW];
  assign quo_o = quo_r[QW];

endmodule

`default_nettype wire

// ----- hdl/pld_sqrt.sv -----
// ----------------------------------------------------------------------------
// pld_sqrt
// Digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_sqrt import pld_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire pld_ctl_t      ctl_i,
  input  wire logic [QW-1:0] rad_i,
  output pld_ctl_t           ctl_o,
  output logic [RW-1:0]      root_o
);

  pld_ctl_t      ctl_r [1:RW];
  logic [QW-1:0] x_r   [1:RW];
  logic [QW-1:0] res_r [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [QW-1:0] ONE = QW'(1) << (QW-2-2*k);
    pld_ctl_t      ctl_cur;
    logic [QW-1:0] x_cur;
    logic [QW-1:0] res_cur;
    logic [QW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign ctl_cur = ctl_i;
      assign x_cur   = rad_i;
      assign res_cur = '0;
    end else begin : g_rest
      assign ctl_cur = ctl_r[k];
      assign x_cur   = x_r[k];
      assign res_cur = res_r[k];
    end

    assign trial = res_cur + ONE;
    assign take  = (x_cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (adv) begin
        ctl_r[k+1] <= ctl_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[k+1]   <= take ? (x_cur - trial) : x_cur;
        res_r[k+1] <= take ? ((res_cur >> 1) + ONE) : (res_cur >> 1);
      end
    end
  end

  assign ctl_o  = ctl_r[RW];
  assign root_o = res_r[RW][RW-1:0];

endmodule

`default_nettype wire

// ----- hdl/point_to_line_distance_3d.sv -----
// ----------------------------------------------------------------------------
// point_to_line_distance_3d
// Distance from a point p to the line through a and b, signed fixed point.
//
// in_ch takes one query word (p, a, b) per unstalled cycle; out_ch returns
// one word per query, in order: distance = floor(|(p-a) x (b-a)| / |b-a|)
// in raw units, with degenerate (|b-a| below eps_threshold or zero,
// distance 0) and saturated (distance reached 2^32, distance all ones).
// The pipeline is 7 front stages, 64 divider stages (one quotient bit
// each), 32 square-root stages (one root bit each) and the output
// register. Throughput is one word per cycle while out_ch is not stalled.
// The whole pipeline advances together; when out_ch is stalled with a word
// held, in_ch.ready drops and every stage holds its word.
// Reset (synchronous, rst_n low) clears all valid bits and sets
// eps_threshold to 1. The APB port writes eps_threshold at byte address 0;
// write it only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module point_to_line_distance_3d import pld_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pld_in_if.sink                 in_ch,
  pld_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  // global advance: one output register parts the pipe from the receiver
  logic adv;

  logic [EPS_W-1:0]   eps_r;
  logic [2*EPS_W-1:0] eps2_r;

  pld_query_t        qry;
  pld_ctl_t          front_ctl, div_ctl, sqrt_ctl;
  logic [CSQ_W-1:0]  csq;
  logic [DSQ_W-1:0]  dsq;
  logic [QW-1:0]     quo;
  logic [RW-1:0]     root;

  logic              out_vld_r;
  logic [RW-1:0]     dist_r, dist_nxt;
  logic              degen_r, sat_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---- configuration ----
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_EPS_THRESHOLD) ?
                  DATA_W'(eps_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= EPS_RESET;
      eps2_r <= (2*EPS_W)'(1);
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[ADDR_W-1:2] == REG_EPS_THRESHOLD) begin
        eps_r <= pwdata[EPS_W-1:0];
      end
      // threshold squared, registered from eps_r, so it settles in the cycle after eps_r takes a write
      eps2_r <= (2*EPS_W)'(eps_r) * (2*EPS_W)'(eps_r);
    end
  end

  assign qry = '{point_x: in_ch.point_x, point_y: in_ch.point_y,
                 point_z: in_ch.point_z, line_a_x: in_ch.line_a_x,
                 line_a_y: in_ch.line_a_y, line_a_z: in_ch.line_a_z,
                 line_b_x: in_ch.line_b_x, line_b_y: in_ch.line_b_y,
                 line_b_z: in_ch.line_b_z};

  pld_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (in_ch.valid),
    .qry_i  (qry),
    .eps2_i (eps2_r),
    .ctl_o  (front_ctl),
    .csq_o  (csq),
    .dsq_o  (dsq)
  );

  pld_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (front_ctl),
    .csq_i (csq),
    .dsq_i (dsq),
    .ctl_o (div_ctl),
    .quo_o (quo)
  );

  // floor(sqrt(floor(x))) == floor(sqrt(x)), so the root of the integer
  // quotient is the truncated distance
  pld_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_i  (div_ctl),
    .rad_i  (quo),
    .ctl_o  (sqrt_ctl),
    .root_o (root)
  );

  // ---- output register ----
  always_comb begin
    if (sqrt_ctl.degen) begin
      dist_nxt = '0;
    end else if (sqrt_ctl.sat) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= sqrt_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r  <= dist_nxt;
      degen_r <= sqrt_ctl.degen;
      sat_r   <= sqrt_ctl.sat && !sqrt_ctl.degen;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.distance   = dist_r;
  assign out_ch.degenerate = degen_r;
  assign out_ch.saturated  = sat_r;

  // ---- assertions ----
  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && degen_r |-> dist_r == '0 && !sat_r)
    else $error("degenerate word with nonzero distance");

  a_sat_ones : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && sat_r |-> dist_r == '1)
    else $error("saturated word without full-scale distance");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(dist_r))
    else $error("held output word changed");

  a_ready_adv : assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input blocked with empty output register");

endmodule

`default_nettype wire

// ----- verif/tb_point_to_line_distance_3d.sv -----
// ----------------------------------------------------------------------------
// tb_point_to_line_distance_3d
// Self-checking bench for the point-to-line distance pipeline. Query words go
// in over the input channel, and each one's expected distance word is pushed
// into an in-order queue. A monitor compares every distance word as it leaves
// the block. Random gaps are applied on both sides, and eps_threshold is
// changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_point_to_line_distance_3d;
  import pld_pkg::*;

  // Drain margin, longer than the latency of the block.
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [RW-1:0] distance;
    logic          degenerate;
    logic          saturated;
  } dist_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  pld_in_if  in_ch ();
  pld_out_if out_ch ();

  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  point_to_line_distance_3d u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Bench copy of the threshold register
  logic [EPS_W-1:0] eps_shadow;
  dist_word_t       dist_expected_q[$];
  int               mismatch_cnt = 0;
  bit               rx_stall_long = 0;

  // Exact distance: widths chosen so nothing wraps.
  // d in 33 bits, cross terms 67 bits, |c|^2 up to 132 bits.
  function automatic dist_word_t dist_predict(pld_query_t qw);
    logic signed [34:0]  dx, dy, dz, ux, uy, uz;
    logic signed [69:0]  cx, cy, cz;
    logic [159:0]        dsq, csq, eps2, t;
    logic [31:0]         q, cand;
    dist_word_t          r;
    dx = 35'(qw.line_b_x) - 35'(qw.line_a_x);
    dy = 35'(qw.line_b_y) - 35'(qw.line_a_y);
    dz = 35'(qw.line_b_z) - 35'(qw.line_a_z);
    ux = 35'(qw.point_x) - 35'(qw.line_a_x);
    uy = 35'(qw.point_y) - 35'(qw.line_a_y);
    uz = 35'(qw.point_z) - 35'(qw.line_a_z);
    dsq = 160'(70'(dx * dx)) + 160'(70'(dy * dy)) + 160'(70'(dz * dz));
    eps2 = 160'(eps_shadow) * 160'(eps_shadow);
    r = '0;
    // Degenerate line: zero direction, or shorter than the threshold
    if (dsq == 0 || dsq < eps2) begin
      r.degenerate = 1'b1;
      return r;
    end
    cx = 70'(uy) * 70'(dz) - 70'(uz) * 70'(dy);
    cy = 70'(uz) * 70'(dx) - 70'(ux) * 70'(dz);
    cz = 70'(ux) * 70'(dy) - 70'(uy) * 70'(dx);
    csq = 160'(140'(cx) * 140'(cx)) + 160'(140'(cy) * 140'(cy))
        + 160'(140'(cz) * 140'(cz));
    // Too large: distance reaches 2^32 raw units
    if ((dsq << 64) <= csq) begin
      r.distance  = '1;
      r.saturated = 1'b1;
      return r;
    end
    // Truncated root by bitwise search
    q = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = q | (32'd1 << b);
      t = 160'(64'(cand) * 64'(cand)) * dsq;
      if (t <= csq) q = cand;
    end
    r.distance = q;
    return r;
  endfunction

  // Gap length: none half the time, otherwise mostly short, rarely long
  function automatic int pick_gap();
    int s;
    s = $urandom_range(0, 99);
    if (s < 50) return 0;
    if (s < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back words need no gap.
  task automatic send_query(pld_query_t qw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.point_x  <= qw.point_x;
    in_ch.point_y  <= qw.point_y;
    in_ch.point_z  <= qw.point_z;
    in_ch.line_a_x <= qw.line_a_x;
    in_ch.line_a_y <= qw.line_a_y;
    in_ch.line_a_z <= qw.line_a_z;
    in_ch.line_b_x <= qw.line_b_x;
    in_ch.line_b_y <= qw.line_b_y;
    in_ch.line_b_z <= qw.line_b_z;
    do @(posedge clk); while (!in_ch.ready);
    dist_expected_q.push_back(dist_predict(qw));
    @(negedge clk);
  endtask

  task automatic write_eps(logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1;
    paddr <= {REG_EPS_THRESHOLD, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    eps_shadow = value[EPS_W-1:0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Stop sending and let the pipeline empty before touching the register
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (dist_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2 * 65536 * 16)) - 65536 * 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic pld_query_t rand_query();
    pld_query_t qw;
    int shape;
    qw = {$urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom};
    shape = $urandom_range(0, 9);
    if (shape < 3) begin
      qw.point_x = rand_coord(); qw.point_y = rand_coord();
      qw.point_z = rand_coord(); qw.line_a_x = rand_coord();
      qw.line_a_y = rand_coord(); qw.line_a_z = rand_coord();
      qw.line_b_x = rand_coord(); qw.line_b_y = rand_coord();
      qw.line_b_z = rand_coord();
    end else if (shape < 6) begin
      // short line near a: probes the threshold
      qw.line_b_x = qw.line_a_x + 32'($signed($urandom_range(0, 200)) - 100);
      qw.line_b_y = qw.line_a_y + 32'($signed($urandom_range(0, 200)) - 100);
      qw.line_b_z = qw.line_a_z + 32'($signed($urandom_range(0, 200)) - 100);
    end else if (shape < 8) begin
      // moderate scale geometry: unsaturated distances
      qw.point_x  = 32'($signed($urandom) >>> $urandom_range(4, 14));
      qw.point_y  = 32'($signed($urandom) >>> $urandom_range(4, 14));
      qw.point_z  = 32'($signed($urandom) >>> $urandom_range(4, 14));
      qw.line_a_x = 32'($signed($urandom) >>> $urandom_range(4, 14));
      qw.line_a_y = 32'($signed($urandom) >>> $urandom_range(4, 14));
      qw.line_a_z = 32'($signed($urandom) >>> $urandom_range(4, 14));
      qw.line_b_x = 32'($signed($urandom) >>> $urandom_range(4, 14));
      qw.line_b_y = 32'($signed($urandom) >>> $urandom_range(4, 14));
      qw.line_b_z = 32'($signed($urandom) >>> $urandom_range(4, 14));
    end
    return qw;
  endfunction

  // Receiver side: random backpressure on the distance channel
  always @(negedge clk) begin
    if (rx_stall_long) out_ch.ready <= ($urandom_range(0, 9) == 0);
    else out_ch.ready <= (pick_gap() == 0) || ($urandom_range(0, 3) != 0);
  end

  // Distance word checker
  always @(posedge clk) begin
    dist_word_t got, exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.distance, out_ch.degenerate, out_ch.saturated};
      if (dist_expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: unexpected distance word %h/%b/%b", got.distance,
                   got.degenerate, got.saturated);
      end else begin
        exp_w = dist_expected_q.pop_front();
        if (got !== exp_w) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: distance exp %h deg %b sat %b, got %h deg %b sat %b",
                     exp_w.distance, exp_w.degenerate, exp_w.saturated,
                     got.distance, got.degenerate, got.saturated);
        end
      end
    end
  end

  // ---- tests ----

  // Extremes of every coordinate, coincident points, saturation, tiny cases
  task automatic test_directed();
    pld_query_t qw;
    qw = '0;
    send_query(qw);                               // coincident a == b
    qw.line_b_x = 32'sd65536; qw.point_y = 32'sd65536;
    send_query(qw);                               // unit distance
    qw.point_y = 32'sd3; send_query(qw);          // small exact distance
    qw = '0; qw.line_b_x = 32'sd1; send_query(qw); // |d| exactly 1
    qw = {9{32'h7FFF_FFFF}}; send_query(qw);
    qw = {9{32'h8000_0000}}; send_query(qw);
    // Large distances near saturation: huge offsets, tiny and long directions
    qw = '0; qw.point_y = 32'h7FFF_FFFF; qw.point_z = 32'h8000_0000;
    qw.line_a_x = 32'h8000_0000; qw.line_b_x = 32'h8000_0001;
    send_query(qw);
    qw.line_a_y = 32'h8000_0000; qw.line_b_z = 32'h7FFF_FFFF;
    send_query(qw);
    qw = '0; qw.line_a_x = 32'h8000_0000; qw.line_b_x = 32'h7FFF_FFFF;
    qw.point_y = 32'h7FFF_FFFF; qw.point_z = 32'h8000_0000;
    send_query(qw);
    // Point on the line
    qw = '0; qw.line_b_x = 32'sd100; qw.line_b_y = 32'sd200;
    qw.point_x = 32'sd50; qw.point_y = 32'sd100;
    send_query(qw);
    qw = {32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
          32'h8000_0001, 32'h7FFF_FFFE, 32'h1234_5678, 32'hFEDC_BA98,
          32'h0F0F_0F0F};
    send_query(qw);
    repeat (8) send_query(rand_query());
  endtask

  // Threshold sweep: each setting with queries around the boundary
  task automatic test_eps_sweep();
    logic [DATA_W-1:0] settings[5];
    pld_query_t qw;
    settings = '{32'd0, 32'd65535, 32'hFFFF_0100, 32'd100, 32'd1};
    foreach (settings[i]) begin
      wait_idle();
      write_eps(settings[i]);
      qw = '0; send_query(qw);              // zero direction stays degenerate
      qw.line_b_x = 32'(eps_shadow);        // exactly at the threshold
      qw.point_y = 32'sd12345; send_query(qw);
      qw.line_b_x = 32'(eps_shadow) - 1; send_query(qw);
      repeat (60) send_query(rand_query());
    end
  endtask

  // Bulk random run, with a stretch of heavy receiver stall
  task automatic test_random();
    for (int n = 0; n < 700; n++) begin
      rx_stall_long = (n >= 300 && n < 400);
      send_query(rand_query());
    end
    rx_stall_long = 0;
  endtask

  initial begin
    pld_query_t zero_q;
    zero_q = '0;
    in_ch.valid = 1'b0;
    {in_ch.point_x, in_ch.point_y, in_ch.point_z, in_ch.line_a_x,
     in_ch.line_a_y, in_ch.line_a_z, in_ch.line_b_x, in_ch.line_b_y,
     in_ch.line_b_z} = zero_q;
    out_ch.ready = 1'b0;
    eps_shadow = EPS_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_eps_sweep();
    test_random();

    wait_idle();
    if (mismatch_cnt == 0 && dist_expected_q.size() == 0)
      $display("point_to_line_distance_3d test passed");
    else
      $display("point_to_line_distance_3d test failed");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("point_to_line_distance_3d test failed");
    $finish;
  end

endmodule
